FILE: design/lfu_pkg.sv
// Shared constants for the LFU cache table: field widths, reset values and codes.
// No dependencies; used by lfu_cache_table_top.
`default_nettype none

package lfu_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int CFG_W = 5;

	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [CNT_W-1:0] COUNT_INIT = 32'd1;

endpackage

`default_nettype wire

FILE: design/lfu_cache_table_top.sv
// Top level of the LFU cache table: sequencer, scan/update datapath, valid bits, registers.
// Depends on lfu_pkg and lfu_ram.
`default_nettype none

// Channel    Direction  Handshake                      Payload
// ---------  ---------  -----------------------------  ---------------------------------------
// command    in         start high while busy low      mode, key, value
// result     out        done high for one cycle        hit, read_value, evicted, evicted_key
// config     in         cfg_we high (no wait)          cfg_wdata (capacity)
//
// Each command runs two sequential passes over the entry table through its single
// read port: a lookup pass (key match, victim search, first free slot) and, when the
// table changes, an update pass (recency ranks, counts, new entry).
// A get miss or a put with capacity zero ends after the lookup pass; every other command
// also runs the update pass.
// done is high in the first cycle with busy low; a new command may be started in that cycle.
// arst_n clears the valid bits, the occupancy count and the sequencer; capacity resets
// to 16. The receiver cannot stall; the result ports hold their values until the next command.

module lfu_cache_table_top #(
	parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              mode,
	input  wire logic signed [lfu_pkg::KEY_W-1:0]  key,
	input  wire logic signed [lfu_pkg::VAL_W-1:0]  value,
	input  wire logic                              cfg_we,
	input  wire logic        [lfu_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                                   done,
	output logic                                   hit,
	output logic signed      [lfu_pkg::VAL_W-1:0]  read_value,
	output logic                                   evicted,
	output logic signed      [lfu_pkg::KEY_W-1:0]  evicted_key
);

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W = IDX_W;
	localparam int OCC_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CMP_W-1:0] CAP_LIM  = CMP_W'(CAPACITY);

	typedef struct packed {
		logic [lfu_pkg::KEY_W-1:0] key;
		logic [lfu_pkg::VAL_W-1:0] val;
		logic [lfu_pkg::CNT_W-1:0] cnt;
		logic [RANK_W-1:0]         rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FLUSH
	} state_t;

	typedef enum logic {
		UPD_TOUCH,
		UPD_INSERT
	} upd_t;

	state_t                       state_q;
	logic [lfu_pkg::CFG_W-1:0]    capacity_q;
	logic [CAPACITY-1:0]          valid_q;
	logic [OCC_W-1:0]             occ_q;

	logic                         mode_q;
	logic [lfu_pkg::KEY_W-1:0]    key_q;
	logic [lfu_pkg::VAL_W-1:0]    value_q;

	logic [IDX_W-1:0]             idx_q;
	logic                         rd_act_s1;
	logic                         rd_upd_s1;
	logic [IDX_W-1:0]             rd_idx_s1;

	logic                         hit_found_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [RANK_W-1:0]            hit_rank_q;
	logic [lfu_pkg::VAL_W-1:0]    hit_val_q;

	logic                         vic_found_q;
	logic [IDX_W-1:0]             vic_idx_q;
	logic [lfu_pkg::CNT_W-1:0]    vic_cnt_q;
	logic [RANK_W-1:0]            vic_rank_q;
	logic [lfu_pkg::KEY_W-1:0]    vic_key_q;

	logic                         free_found_q;
	logic [IDX_W-1:0]             free_idx_q;

	upd_t                         upd_q;
	logic                         evict_q;
	logic [IDX_W-1:0]             tgt_idx_q;
	logic [RANK_W-1:0]            ref_rank_q;

	logic                         done_q;
	logic                         hit_q;
	logic [lfu_pkg::VAL_W-1:0]    rdval_q;
	logic                         ev_q;
	logic [lfu_pkg::KEY_W-1:0]    evk_q;

	logic [ENTRY_W-1:0]           mem_rdata;
	logic [ENTRY_W-1:0]           mem_wdata;
	logic                         mem_we;
	entry_t                       rd_ent;
	entry_t                       wr_ent;

	logic                         rd_valid;
	logic                         key_match;
	logic                         vic_better;
	logic                         tgt_sel;
	logic                         rank_inc;
	logic [RANK_W-1:0]            rank_next;
	logic [lfu_pkg::CNT_W-1:0]    cnt_next;

	logic [CMP_W-1:0]             cap_ext;
	logic [CMP_W-1:0]             cap_eff;
	logic                         full;
	logic [IDX_W-1:0]             ins_slot;

	// Entry table: one word per slot, read once per cycle during each pass.
	lfu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(rd_idx_s1),
		.wdata(mem_wdata),
		.raddr(idx_q),
		.rdata(mem_rdata)
	);

	// Lookup pass compare logic on the word returned for slot rd_idx_s1.
	always_comb begin
		rd_ent     = entry_t'(mem_rdata);
		rd_valid   = valid_q[rd_idx_s1];
		key_match  = rd_valid && (rd_ent.key == key_q);
		// Lowest count wins; on equal counts the older (higher) rank wins.
		vic_better = rd_valid && (!vic_found_q || (rd_ent.cnt < vic_cnt_q) ||
			((rd_ent.cnt == vic_cnt_q) && (rd_ent.rank > vic_rank_q)));
	end

	// Update pass: shared rank adjust unit and write-back word.
	always_comb begin
		tgt_sel = (rd_idx_s1 == tgt_idx_q);
		if (upd_q == UPD_TOUCH) begin
			// Entries newer than the touched one age by one.
			rank_inc = (rd_ent.rank < ref_rank_q);
		end else begin
			// Eviction closes the victim's gap, the insert pushes everyone back:
			// entries older than the victim keep their rank, the rest age by one.
			rank_inc = !(evict_q && (rd_ent.rank > ref_rank_q));
		end
		rank_next = rd_ent.rank + RANK_W'(rank_inc);
		cnt_next  = (rd_ent.cnt == lfu_pkg::COUNT_MAX) ? rd_ent.cnt
			: rd_ent.cnt + lfu_pkg::CNT_W'(1);

		wr_ent = rd_ent;
		if (tgt_sel) begin
			wr_ent.key  = key_q;
			wr_ent.rank = '0;
			if (upd_q == UPD_TOUCH) begin
				wr_ent.val = (mode_q == lfu_pkg::MODE_PUT) ? value_q : rd_ent.val;
				wr_ent.cnt = cnt_next;
			end else begin
				wr_ent.val = value_q;
				wr_ent.cnt = lfu_pkg::COUNT_INIT;
			end
		end else begin
			wr_ent.rank = rank_next;
		end
		mem_wdata = ENTRY_W'(wr_ent);
		mem_we    = rd_act_s1 && rd_upd_s1 && (tgt_sel || rd_valid);
	end

	// Replacement decision from the lookup results.
	always_comb begin
		cap_ext  = CMP_W'(capacity_q);
		cap_eff  = (cap_ext > CAP_LIM) ? CAP_LIM : cap_ext;
		full     = (CMP_W'(occ_q) >= cap_eff);
		// After an eviction the lowest free slot is the lower of the old free slot and
		// the victim.
		ins_slot = (free_found_q && (!full || (free_idx_q < vic_idx_q))) ? free_idx_q
			: vic_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			capacity_q   <= lfu_pkg::CAP_RESET;
			valid_q      <= '0;
			occ_q        <= '0;
			rd_act_s1    <= 1'b0;
			rd_upd_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_act_s1 <= 1'b0;

			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end

			// Lookup pass: collect match, victim and first free slot.
			if (rd_act_s1 && !rd_upd_s1) begin
				if (key_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
					hit_idx_q   <= rd_idx_s1;
					hit_rank_q  <= rd_ent.rank;
					hit_val_q   <= rd_ent.val;
				end
				if (vic_better) begin
					vic_found_q <= 1'b1;
					vic_idx_q   <= rd_idx_s1;
					vic_cnt_q   <= rd_ent.cnt;
					vic_rank_q  <= rd_ent.rank;
					vic_key_q   <= rd_ent.key;
				end
				if (!rd_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= rd_idx_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q       <= mode;
						key_q        <= key;
						value_q      <= value;
						idx_q        <= '0;
						hit_found_q  <= 1'b0;
						vic_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_act_s1 <= 1'b1;
					rd_upd_s1 <= 1'b0;
					rd_idx_s1 <= idx_q;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_PLAN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_PLAN: begin
					// Drain the last lookup word.
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					idx_q   <= '0;
					hit_q   <= hit_found_q;
					rdval_q <= '0;
					ev_q    <= 1'b0;
					evk_q   <= '0;
					if (mode_q == lfu_pkg::MODE_GET) begin
						if (hit_found_q) begin
							rdval_q    <= hit_val_q;
							upd_q      <= UPD_TOUCH;
							evict_q    <= 1'b0;
							tgt_idx_q  <= hit_idx_q;
							ref_rank_q <= hit_rank_q;
							state_q    <= ST_UPDATE;
						end else begin
							rdval_q <= lfu_pkg::MISS_VALUE;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (capacity_q == '0) begin
						// Put with capacity zero: leave the table alone.
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (hit_found_q) begin
						upd_q      <= UPD_TOUCH;
						evict_q    <= 1'b0;
						tgt_idx_q  <= hit_idx_q;
						ref_rank_q <= hit_rank_q;
						state_q    <= ST_UPDATE;
					end else begin
						upd_q      <= UPD_INSERT;
						evict_q    <= full;
						tgt_idx_q  <= ins_slot;
						ref_rank_q <= vic_rank_q;
						ev_q       <= full;
						evk_q      <= full ? vic_key_q : '0;
						if (full) begin
							valid_q[vic_idx_q] <= 1'b0;
						end else begin
							occ_q <= occ_q + OCC_W'(1);
						end
						valid_q[ins_slot] <= 1'b1;
						state_q           <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					rd_act_s1 <= 1'b1;
					rd_upd_s1 <= 1'b1;
					rd_idx_s1 <= idx_q;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					// Write back the last word, then report.
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = rdval_q;
	assign evicted     = ev_q;
	assign evicted_key = evk_q;

`ifndef SYNTHESIS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) == $countones(valid_q))
		else $error("occupancy count disagrees with valid bits");

	a_start_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in flight");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> !hit)
		else $error("eviction reported on a hit");
`endif

endmodule

`default_nettype wire

FILE: design/lfu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
